/* rtl/rmq_pkg.sv */
// Shared types for the rotation matrix to quaternion unit.
package rmq_pkg;

  // Which quaternion component is the large one, picked from the diagonal.
  typedef enum logic [1:0] {
    COMP_W = 2'd0,
    COMP_X = 2'd1,
    COMP_Y = 2'd2,
    COMP_Z = 2'd3
  } comp_t;

endpackage

/* rtl/rmq_if.sv */
// Valid/ready channel interfaces for matrix input and quaternion output.
interface rmq_mat_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

interface rmq_quat_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic         invalid;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, invalid, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, invalid, output ready);
endinterface

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// Rotation matrix to unit quaternion converter, fully pipelined.
//
// Channels: mat carries one 3x3 row-major matrix per beat (r00..r22, signed,
// FRAC_BITS fraction bits). quat returns one beat per matrix: quat_w..quat_z
// in the same format, saturated, plus invalid when the radicand was not
// positive (then all four components are zero).
// Pipeline: one prep stage (trace, branch pick, radicand, numerators), one
// stage per root bit of the square root, one divider setup stage, one stage
// per quotient bit of the three parallel long dividers, one output register.
// Here RW = (DATA_WIDTH+FRAC_BITS+3)/2 is the number of root bits and
// NW = DATA_WIDTH+FRAC_BITS+2 is the number of quotient bits.
// Throughput: one matrix per cycle while quat.ready does not stall the output; results come back in order.
// Stall: every stage moves only while the output register is empty or being
// taken, so mat.ready follows quat.ready and a stall holds every beat in place.
// Reset clears all stage valid bits; data registers are not reset.
module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic            clk,
  input  logic            rst,
  rmq_mat_if.sink         mat,
  rmq_quat_if.source      quat
);
  import rmq_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int TW = W + 3;              // signed radicand / sums
  localparam int TU = W + 2;              // positive radicand magnitude
  localparam int V  = TU + F;             // radicand scaled for the root
  localparam int RW = (V + 1) / 2;        // root bits = sqrt stages
  localparam int MW = W + 1;              // numerator magnitude
  localparam int NW = W + F + 2;          // dividend bits = divide stages
  localparam int DW = RW + 1;             // divisor 2*root

  localparam logic signed [TW-1:0] ONE = TW'(2**F);
  localparam int CW = (RW > W) ? RW : W;
  localparam logic [CW-1:0]        HI_C = CW'({(W-1){1'b1}});
  localparam logic signed [W:0]    HI_S = $signed({2'b00, {(W-1){1'b1}}});
  localparam logic [NW-1:0]        LIM  = NW'(1) << (W - 1);

  typedef struct packed {
    comp_t                big;
    logic                 inv;
    logic [2:0]           neg;
    logic [2:0][MW-1:0]   mag;
  } sa_t;

  typedef struct packed {
    comp_t                big;
    logic                 inv;
    logic [2:0]           neg;
    logic [RW-1:0]        root;
  } sb_t;

  logic en;
  assign en        = !quat.valid || quat.ready;
  assign mat.ready = en;

  // ---------------- prep: branch, radicand, numerators ----------------
  logic signed [TW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [TW-1:0] tr, tval;
  logic signed [TW-1:0] nl [3];
  comp_t                big_c;
  sa_t                  sa_c;

  assign a00 = TW'($signed(mat.r00));
  assign a01 = TW'($signed(mat.r01));
  assign a02 = TW'($signed(mat.r02));
  assign a10 = TW'($signed(mat.r10));
  assign a11 = TW'($signed(mat.r11));
  assign a12 = TW'($signed(mat.r12));
  assign a20 = TW'($signed(mat.r20));
  assign a21 = TW'($signed(mat.r21));
  assign a22 = TW'($signed(mat.r22));
  assign tr  = a00 + a11 + a22;

  always_comb begin
    // lanes hold the three small components in w, x, y, z order
    if (tr > 0) begin
      big_c = COMP_W;
      tval  = ONE + tr;
      nl[0] = a21 - a12; nl[1] = a02 - a20; nl[2] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      big_c = COMP_X;
      tval  = ONE + a00 - a11 - a22;
      nl[0] = a21 - a12; nl[1] = a01 + a10; nl[2] = a02 + a20;
    end else if (a11 > a22) begin
      big_c = COMP_Y;
      tval  = ONE + a11 - a00 - a22;
      nl[0] = a02 - a20; nl[1] = a01 + a10; nl[2] = a12 + a21;
    end else begin
      big_c = COMP_Z;
      tval  = ONE + a22 - a00 - a11;
      nl[0] = a10 - a01; nl[1] = a02 + a20; nl[2] = a12 + a21;
    end
    sa_c.big = big_c;
    sa_c.inv = !(tval > 0);
    for (int j = 0; j < 3; j++) begin
      sa_c.neg[j] = nl[j][TW-1];
      sa_c.mag[j] = nl[j][TW-1] ? MW'(-nl[j]) : MW'(nl[j]);
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic [V:0] sq_x [RW+1];
  logic [V:0] sq_r [RW+1];
  logic       sq_v [RW+1];
  sa_t        sq_s [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_s[0] <= sa_c;
      sq_x[0] <= sa_c.inv ? '0 : ((V+1)'(tval[TU-1:0]) << F);
      sq_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sq
    localparam logic [V:0] BIT = (V+1)'(1) << (2 * (RW - 1 - i));
    logic [V:0] trial;
    assign trial = sq_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_s[i+1] <= sq_s[i];
        if (sq_x[i] >= trial) begin
          sq_x[i+1] <= sq_x[i] - trial;
          sq_r[i+1] <= (sq_r[i] >> 1) + BIT;
        end else begin
          sq_x[i+1] <= sq_x[i];
          sq_r[i+1] <= sq_r[i] >> 1;
        end
      end
    end
  end

  // ---------------- dividers, one quotient bit per stage ----------------
  logic [RW-1:0]          root_c;
  logic [2:0][NW-1:0]     dv_n   [NW+1];
  logic [2:0][DW-1:0]     dv_rem [NW+1];
  logic [2:0][NW-1:0]     dv_q   [NW+1];
  logic [DW-1:0]          dv_d   [NW+1];
  logic                   dv_v   [NW+1];
  sb_t                    dv_s   [NW+1];

  assign root_c = sq_r[RW][RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_s[0].big  <= sq_s[RW].big;
      dv_s[0].inv  <= sq_s[RW].inv;
      dv_s[0].neg  <= sq_s[RW].neg;
      dv_s[0].root <= root_c;
      dv_d[0]      <= DW'(root_c) << 1;
      for (int j = 0; j < 3; j++) begin
        // round half away: (mag << F) + root over 2*root
        dv_n[0][j]   <= (NW'(sq_s[RW].mag[j]) << F) + NW'(root_c);
        dv_rem[0][j] <= '0;
        dv_q[0][j]   <= '0;
      end
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_dv
    logic [2:0][DW:0] sh;
    logic [2:0]       ge;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        sh[j] = {dv_rem[k][j], dv_n[k][j][NW-1]};
        ge[j] = sh[j] >= {1'b0, dv_d[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[k+1] <= dv_s[k];
        dv_d[k+1] <= dv_d[k];
        for (int j = 0; j < 3; j++) begin
          dv_rem[k+1][j] <= ge[j] ? DW'(sh[j] - {1'b0, dv_d[k]}) : sh[j][DW-1:0];
          dv_n[k+1][j]   <= dv_n[k][j] << 1;
          dv_q[k+1][j]   <= {dv_q[k][j][NW-2:0], ge[j]};
        end
      end
    end
  end

  // ---------------- saturate, place components, output register ----------------
  sb_t                 fs;
  logic [2:0][W-1:0]   lane;
  logic [W-1:0]        big_v;
  logic [3:0][W-1:0]   comp;
  logic [RW-1:0]       half;

  assign fs   = dv_s[NW];
  assign half = fs.root >> 1;
  assign big_v = (CW'(half) > HI_C) ? HI_C[W-1:0] : W'(half);

  always_comb begin
    logic [NW-1:0]   qclip;
    logic signed [W:0] sv;
    for (int j = 0; j < 3; j++) begin
      qclip = (dv_q[NW][j] > LIM) ? LIM : dv_q[NW][j];
      sv    = $signed({1'b0, qclip[W-1:0]});
      if (fs.neg[j]) sv = -sv;
      lane[j] = (sv > HI_S) ? HI_S[W-1:0] : sv[W-1:0];
    end
    for (int c = 0; c < 4; c++) begin
      if (fs.inv) begin
        comp[c] = '0;
      end else if (c == int'(fs.big)) begin
        comp[c] = big_v;
      end else if (c < int'(fs.big)) begin
        comp[c] = lane[c];
      end else begin
        comp[c] = lane[(c > 0) ? c - 1 : 0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat.quat_w  <= comp[0];
      quat.quat_x  <= comp[1];
      quat.quat_y  <= comp[2];
      quat.quat_z  <= comp[3];
      quat.invalid <= fs.inv;
    end
  end

endmodule

/* rtl/rmq_checker.sv */
// Port-level assertions for the rotation matrix to quaternion unit.
module rmq_assertions #(parameter int W = 16) (
  input logic         clk,
  input logic         rst,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] quat_w,
  input logic [W-1:0] quat_x,
  input logic [W-1:0] quat_y,
  input logic [W-1:0] quat_z,
  input logic         invalid
);

  // input side moves exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not track output stall");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && invalid) |->
      (quat_w == '0 && quat_x == '0 && quat_y == '0 && quat_z == '0))
    else $error("invalid beat with nonzero quaternion");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y)
       && $stable(quat_z) && $stable(invalid)))
    else $error("stalled output beat changed");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_assertions #(.W(DATA_WIDTH)) u_rmq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (mat.ready),
  .out_valid (quat.valid),
  .out_ready (quat.ready),
  .quat_w    (quat.quat_w),
  .quat_x    (quat.quat_x),
  .quat_y    (quat.quat_y),
  .quat_z    (quat.quat_z),
  .invalid   (quat.invalid)
);

/* verif/rmq_checker.sv */
// Quaternion predictor and scoreboard for the rotation matrix unit.
module rmq_checker #(
  parameter int DW = 16,
  parameter int FB = 14
) (
  input  logic   clk,
  input  logic   rst,
  rmq_mat_if     mat,
  rmq_quat_if    quat,
  output int     fail_count,
  output int     pending
);
  import rmq_pkg::*;

  typedef struct packed {
    logic [DW-1:0] w, x, y, z;
    logic          inv;
  } quat_t;

  quat_t quat_q[$];

  function automatic longint sx(logic [DW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [DW-1:0] clip(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[DW-1:0];
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // n / (2*root) in Q format, rounded half away from zero
  function automatic logic [DW-1:0] ratio(longint n, longint root);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = ((m <<< FB) + root) / (root <<< 1);
    if (q > (longint'(1) <<< (DW - 1))) q = longint'(1) <<< (DW - 1);
    return clip((n < 0) ? -q : q);
  endfunction

  function automatic quat_t to_quat(logic [9*DW-1:0] m);
    longint a[9];
    longint n[4];
    longint t, tr, root;
    comp_t big;
    quat_t res;
    logic [DW-1:0] c[4];
    for (int i = 0; i < 9; i++) a[i] = sx(m[(8-i)*DW +: DW]);
    tr = a[0] + a[4] + a[8];
    n = '{0, 0, 0, 0};
    if (tr > 0) begin
      big = COMP_W; t = tr;
      n[1] = a[7] - a[5]; n[2] = a[2] - a[6]; n[3] = a[3] - a[1];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      big = COMP_X; t = a[0] - a[4] - a[8];
      n[0] = a[7] - a[5]; n[2] = a[1] + a[3]; n[3] = a[2] + a[6];
    end else if (a[4] > a[8]) begin
      big = COMP_Y; t = a[4] - a[0] - a[8];
      n[0] = a[2] - a[6]; n[1] = a[1] + a[3]; n[3] = a[5] + a[7];
    end else begin
      big = COMP_Z; t = a[8] - a[0] - a[4];
      n[0] = a[3] - a[1]; n[1] = a[2] + a[6]; n[2] = a[5] + a[7];
    end
    t = t + (longint'(1) <<< FB);
    if (t <= 0) begin
      res = '0;
      res.inv = 1'b1;
      return res;
    end
    root = int_sqrt(t <<< FB);
    for (int k = 0; k < 4; k++)
      c[k] = (k == int'(big)) ? clip(root >>> 1) : ratio(n[k], root);
    res.w = c[0]; res.x = c[1]; res.y = c[2]; res.z = c[3];
    res.inv = 1'b0;
    return res;
  endfunction

  assign pending = quat_q.size();

  always @(posedge clk) begin
    quat_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (mat.valid && mat.ready)
        quat_q.push_back(to_quat({mat.r00, mat.r01, mat.r02, mat.r10, mat.r11,
                                  mat.r12, mat.r20, mat.r21, mat.r22}));
      if (quat.valid && quat.ready) begin
        if (quat_q.size() == 0) begin
          $error("quat beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = quat_q.pop_front();
          if (quat.invalid !== e.inv || quat.quat_w !== e.w || quat.quat_x !== e.x ||
              quat.quat_y !== e.y || quat.quat_z !== e.z) begin
            if (quat.invalid !== e.inv) $error("invalid exp %0d got %0d", e.inv, quat.invalid);
            if (quat.quat_w !== e.w) $error("quat_w exp %0d got %0d", $signed(e.w),
                                            $signed(quat.quat_w));
            if (quat.quat_x !== e.x) $error("quat_x exp %0d got %0d", $signed(e.x),
                                            $signed(quat.quat_x));
            if (quat.quat_y !== e.y) $error("quat_y exp %0d got %0d", $signed(e.y),
                                            $signed(quat.quat_y));
            if (quat.quat_z !== e.z) $error("quat_z exp %0d got %0d", $signed(e.z),
                                            $signed(quat.quat_z));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  final begin end
endmodule

/* verif/tb_top.sv */
// Testbench top: matrix stimulus, output backpressure and final verdict.
module tb_top;
  localparam int DW = 16;
  localparam int FB = 14;
  localparam int LAT = 51;
  localparam int N_RAND = 1730;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  logic [DW-1:0] m [9];

  rmq_mat_if  #(DW) mat ();
  rmq_quat_if #(DW) quat ();

  rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst), .mat(mat), .quat(quat)
  );

  rmq_checker #(.DW(DW), .FB(FB)) u_chk (
    .clk(clk), .rst(rst), .mat(mat), .quat(quat),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // idling stops once this is set
  logic calm = 1'b0;

  // sink side: ready drops in random stall bursts until calm is set
  initial begin
    int n;
    quat.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        quat.ready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end else begin
        quat.ready <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end
    end
  end

  // one beat; valid stays high across back-to-back beats
  task automatic send_mat();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      mat.valid <= 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk);
    end
    mat.valid <= 1'b1;
    {mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12, mat.r20, mat.r21, mat.r22}
      <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    do @(posedge clk); while (!mat.ready);
  endtask

  function automatic logic [DW-1:0] rnd_word();
    return DW'($urandom);
  endfunction

  // diagonal/off-diagonal values near a real rotation: small perturbation
  function automatic logic [DW-1:0] near(int v);
    return DW'(v + $urandom_range(0, 64) - 32);
  endfunction

  task automatic set_mat(int a0, int a1, int a2, int a3, int a4,
                         int a5, int a6, int a7, int a8);
    m[0] = DW'(a0); m[1] = DW'(a1); m[2] = DW'(a2);
    m[3] = DW'(a3); m[4] = DW'(a4); m[5] = DW'(a5);
    m[6] = DW'(a6); m[7] = DW'(a7); m[8] = DW'(a8);
  endtask

  initial begin
    int k, c, s, ang;
    real th;
    mat.valid = 1'b0;
    {mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12, mat.r20, mat.r21, mat.r22} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, axis flips (each branch), ties, extremes
    set_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);       send_mat();
    set_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);     send_mat();
    set_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);     send_mat();
    set_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);     send_mat();
    set_mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);      send_mat();
    set_mat(0, 0, 0, 0, 0, 0, 0, 0, 0);                   send_mat();  // all-tie -> z
    set_mat(-8192, 0, 0, 0, -8192, 0, 0, 0, -16384);      send_mat();  // r00 = r11 tie
    set_mat(-16384, 0, 0, 0, -8192, 0, 0, 0, -8192);      send_mat();  // r11 = r22 tie
    set_mat(-32768, 0, 0, 0, 0, 0, 0, 0, 32767);          send_mat();
    set_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768);    send_mat();  // z branch
    set_mat(0, 0, 0, 0, 32767, 0, 0, 0, 32767);           send_mat();  // trace > 0
    set_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, -32768);    send_mat();  // y branch
    set_mat(-100, 0, 0, 0, -200, 0, 0, 0, 32767);         send_mat();
    set_mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, -1);  send_mat();
    set_mat(16384, 32767, 32767, -32768, -16384, -32768, 32767, 32767, -16384);
    send_mat();
    set_mat(32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767);
    send_mat();
    set_mat(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_mat();
    set_mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_mat();
    set_mat(-1, 1, 1, 1, -1, 1, 1, 1, -1);                send_mat();  // 1+1 small

    // sender holds off until everything has drained
    mat.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);

    for (k = 0; k < N_RAND; k++) begin
      if (k == N_RAND - 200) calm = 1'b1;
      if (k == N_RAND / 2) begin
        mat.valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1: for (int i = 0; i < 9; i++) m[i] = rnd_word();
        2: begin
          for (int i = 0; i < 9; i++) m[i] = rnd_word() >>> 2;
          m[4 * $urandom_range(0, 2)] = DW'(-$urandom_range(0, 32768));
        end
        default: begin
          // rotation about one axis with random angle, perturbed
          ang = $urandom_range(0, 3599);
          th = ang * 3.14159265358979 / 1800.0;
          c = int'($cos(th) * 16384.0);
          s = int'($sin(th) * 16384.0);
          case ($urandom_range(0, 2))
            0: set_mat(16384, 0, 0, 0, c, -s, 0, s, c);
            1: set_mat(c, 0, s, 0, 16384, 0, -s, 0, c);
            default: set_mat(c, -s, 0, s, c, 0, 0, 0, 16384);
          endcase
          for (int i = 0; i < 9; i++) m[i] = near(int'($signed(m[i])));
          if ($urandom_range(0, 1)) begin
            // mirror two axes: can flip to another branch
            m[0] = -m[0]; m[1] = -m[1]; m[2] = -m[2];
            m[4] = -m[4]; m[3] = -m[3]; m[5] = -m[5];
          end
        end
      endcase
      send_mat();
    end
    mat.valid <= 1'b0;

    wait (pending == 0);
    repeat (LAT + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* rotation_matrix_to_quaternion_unit.f */
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rotation_matrix_to_quaternion_unit.sv
rtl/rmq_checker.sv
verif/rmq_checker.sv
verif/tb_top.sv
